[src/dosa_pkg.sv]
// ----------------------------------------------------------------------------
// dosa_pkg
// Shared types, codes and constants of the dual-owner slot allocator.
// ----------------------------------------------------------------------------
package dosa_pkg;

    // field widths of the command and result ports
    localparam int OP_W       = 3;
    localparam int ENT_W      = 11;
    localparam int STAT_W     = 2;
    localparam int SLOT_OUT_W = 10;

    // ownership rows: slots per row of the ownership memory
    localparam int ROW_SLOTS = 32;
    localparam int COL_W     = 5;

    // default sizes
    localparam int POOL_SLOTS_DEF      = 1024;
    localparam int CLIENT_ENTITIES_DEF = 1152;
    localparam int SERVER_ENTITIES_DEF = 1024;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_CCREATE = 3'd1;
    localparam logic [OP_W-1:0] OP_SCREATE = 3'd2;
    localparam logic [OP_W-1:0] OP_CFREE   = 3'd3;
    localparam logic [OP_W-1:0] OP_SFREE   = 3'd4;
    localparam logic [OP_W-1:0] OP_MIRROR  = 3'd5;
    localparam logic [OP_W-1:0] OP_CGET    = 3'd6;
    localparam logic [OP_W-1:0] OP_SGET    = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ENTITY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_TCAP,
        S_TCHK,
        S_FREE_WR,
        S_MSET,
        S_MSET_WR,
        S_SCAN,
        S_FULL,
        S_EMIT,
        S_CLR
    } t_state;

    typedef enum logic [3:0] {
        A_NONE,
        A_LOAD,
        A_CLR,
        A_TRD,
        A_TCAP,
        A_FREE_RD,
        A_FREE_WR,
        A_MSET,
        A_MSET_WR,
        A_SCAN0,
        A_SCAN,
        A_EMIT
    } t_act;

    // controller to datapath
    typedef struct packed {
        t_act              act;
        logic [STAT_W-1:0] st;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad;
        logic            slot_zero;
        logic            sval_zero;
        logic            found;
        logic            scan_end;
        logic            clr_end;
    } t_dstat;

    // operations that look up the client table as their own
    function automatic logic is_client_op(input logic [OP_W-1:0] op);
        return (op == OP_CCREATE) || (op == OP_CFREE) || (op == OP_CGET);
    endfunction

    // operations whose table and ownership bit are the client's
    function automatic logic uses_client(input logic [OP_W-1:0] op);
        return is_client_op(op) || (op == OP_MIRROR);
    endfunction

endpackage

[src/dosa_ctrl.sv]
// ----------------------------------------------------------------------------
// dosa_ctrl
// Sequencer of the allocator: decodes each item and steps the datapath.
// ----------------------------------------------------------------------------
module dosa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  dosa_pkg::t_dstat i_dstat,
    output dosa_pkg::t_cmd   o_cmd
);

    dosa_pkg::t_state r_state, n_state;
    logic             r_from_op, n_from_op;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dosa_pkg::S_CLR;
            r_from_op <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_from_op <= n_from_op;
        end
    end

    assign busy = (r_state != dosa_pkg::S_IDLE);

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_from_op = r_from_op;
        o_cmd.act = dosa_pkg::A_NONE;
        o_cmd.st  = dosa_pkg::ST_OK;
        unique case (r_state)
            dosa_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.act = dosa_pkg::A_LOAD;
                    n_state   = dosa_pkg::S_DEC;
                end
            end
            dosa_pkg::S_DEC: begin
                if (i_dstat.bad) begin
                    o_cmd.act = dosa_pkg::A_EMIT;
                    o_cmd.st  = dosa_pkg::ST_BAD_ENTITY;
                    n_state   = dosa_pkg::S_IDLE;
                end else if (i_dstat.op == dosa_pkg::OP_CLEAR) begin
                    n_from_op = 1'b1;
                    n_state   = dosa_pkg::S_CLR;
                end else if (i_dstat.op == dosa_pkg::OP_CCREATE ||
                             i_dstat.op == dosa_pkg::OP_SCREATE) begin
                    o_cmd.act = dosa_pkg::A_SCAN0;
                    n_state   = dosa_pkg::S_SCAN;
                end else begin
                    o_cmd.act = dosa_pkg::A_TRD;
                    n_state   = dosa_pkg::S_TCAP;
                end
            end
            dosa_pkg::S_TCAP: begin
                o_cmd.act = dosa_pkg::A_TCAP;
                n_state   = dosa_pkg::S_TCHK;
            end
            dosa_pkg::S_TCHK: begin
                if (i_dstat.op == dosa_pkg::OP_CGET || i_dstat.op == dosa_pkg::OP_SGET) begin
                    o_cmd.act = dosa_pkg::A_EMIT;
                    n_state   = dosa_pkg::S_IDLE;
                end else if (i_dstat.slot_zero) begin
                    if (i_dstat.op == dosa_pkg::OP_MIRROR) begin
                        n_state = dosa_pkg::S_MSET;
                    end else begin
                        o_cmd.act = dosa_pkg::A_EMIT;
                        n_state   = dosa_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.act = dosa_pkg::A_FREE_RD;
                    n_state   = dosa_pkg::S_FREE_WR;
                end
            end
            dosa_pkg::S_FREE_WR: begin
                o_cmd.act = dosa_pkg::A_FREE_WR;
                n_state   = (i_dstat.op == dosa_pkg::OP_MIRROR) ? dosa_pkg::S_MSET
                                                               : dosa_pkg::S_EMIT;
            end
            dosa_pkg::S_MSET: begin
                o_cmd.act = dosa_pkg::A_MSET;
                n_state   = i_dstat.sval_zero ? dosa_pkg::S_EMIT : dosa_pkg::S_MSET_WR;
            end
            dosa_pkg::S_MSET_WR: begin
                o_cmd.act = dosa_pkg::A_MSET_WR;
                n_state   = dosa_pkg::S_EMIT;
            end
            dosa_pkg::S_SCAN: begin
                o_cmd.act = dosa_pkg::A_SCAN;
                if (i_dstat.found) begin
                    n_state = dosa_pkg::S_EMIT;
                end else if (i_dstat.scan_end) begin
                    n_state = dosa_pkg::S_FULL;
                end
            end
            dosa_pkg::S_FULL: begin
                o_cmd.act = dosa_pkg::A_EMIT;
                o_cmd.st  = dosa_pkg::ST_FULL;
                n_state   = dosa_pkg::S_IDLE;
            end
            dosa_pkg::S_EMIT: begin
                o_cmd.act = dosa_pkg::A_EMIT;
                n_state   = dosa_pkg::S_IDLE;
            end
            dosa_pkg::S_CLR: begin
                o_cmd.act = dosa_pkg::A_CLR;
                if (i_dstat.clr_end) begin
                    n_from_op = 1'b0;
                    n_state   = r_from_op ? dosa_pkg::S_EMIT : dosa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dosa_pkg::S_IDLE;
            end
        endcase
    end

    // an accepted item is always decoded next
    a_load_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.act == dosa_pkg::A_LOAD) |=> (r_state == dosa_pkg::S_DEC))
        else $error("load not followed by decode");

    // an exhausted scan reports a full pool
    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dosa_pkg::S_SCAN && i_dstat.scan_end && !i_dstat.found)
        |=> (r_state == dosa_pkg::S_FULL))
        else $error("exhausted scan not reported as full");

    // the clearing sweep runs to its end
    a_clr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dosa_pkg::S_CLR && !i_dstat.clr_end) |=> (r_state == dosa_pkg::S_CLR))
        else $error("clearing sweep cut short");

endmodule

[src/dosa_dp.sv]
// ----------------------------------------------------------------------------
// dosa_dp
// Datapath: ownership rows, entity tables, next-fit row scan and results.
// ----------------------------------------------------------------------------
module dosa_dp #(
    parameter int POOL_SLOTS      = dosa_pkg::POOL_SLOTS_DEF,
    parameter int CLIENT_ENTITIES = dosa_pkg::CLIENT_ENTITIES_DEF,
    parameter int SERVER_ENTITIES = dosa_pkg::SERVER_ENTITIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dosa_pkg::t_cmd                  i_cmd,
    output dosa_pkg::t_dstat                o_dstat,
    input  logic [dosa_pkg::OP_W-1:0]       i_op,
    input  logic [dosa_pkg::ENT_W-1:0]      i_entity,
    input  logic                            i_release_tree,
    output logic                            o_valid,
    output logic [dosa_pkg::STAT_W-1:0]     o_status,
    output logic [dosa_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic [dosa_pkg::SLOT_OUT_W-1:0] o_released_slot,
    output logic                            o_release_tree_out
);

    localparam int SW    = $clog2(POOL_SLOTS);
    localparam int RS    = dosa_pkg::ROW_SLOTS;
    localparam int CLW   = dosa_pkg::COL_W;
    localparam int ROWS  = (POOL_SLOTS + RS - 1) / RS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (CLIENT_ENTITIES > 1) ? $clog2(CLIENT_ENTITIES) : 1;
    localparam int VW    = (SERVER_ENTITIES > 1) ? $clog2(SERVER_ENTITIES) : 1;
    localparam int KW    = $clog2(ROWS + 1);
    localparam int D1    = (ROWS > CLIENT_ENTITIES) ? ROWS : CLIENT_ENTITIES;
    localparam int DEPTH = (D1 > SERVER_ENTITIES) ? D1 : SERVER_ENTITIES;
    localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLX   = SW + RW + CLW;
    localparam int XW    = 13;
    localparam int OXW   = (SW > dosa_pkg::SLOT_OUT_W) ? SW : dosa_pkg::SLOT_OUT_W;

    // memories
    logic [2*RS-1:0] r_own_mem  [ROWS];
    logic [SW-1:0]   r_ctab_mem [CLIENT_ENTITIES];
    logic [SW-1:0]   r_stab_mem [SERVER_ENTITIES];
    logic [2*RS-1:0] r_own_rd;
    logic [SW-1:0]   r_ctab_rd, r_stab_rd;

    // item and working registers
    logic [dosa_pkg::OP_W-1:0]  r_op;
    logic [dosa_pkg::ENT_W-1:0] r_ent;
    logic                       r_rt;
    logic [SW-1:0]              r_last, r_slot, r_sval, r_rel;
    logic [DW-1:0]              r_ccnt;
    logic [RW-1:0]              r_vrow;
    logic [CLW-1:0]             r_scol;
    logic [KW-1:0]              r_k;

    // output registers
    logic                            r_ovalid;
    logic [dosa_pkg::STAT_W-1:0]     r_ostat;
    logic [dosa_pkg::SLOT_OUT_W-1:0] r_oslot, r_orel;
    logic                            r_orto;

    function automatic logic [RW-1:0] row_of(input logic [SW-1:0] s);
        logic [SLX-1:0] e;
        e = SLX'(s);
        return e[RW+CLW-1:CLW];
    endfunction

    function automatic logic [CLW-1:0] col_of(input logic [SW-1:0] s);
        logic [SLX-1:0] e;
        e = SLX'(s);
        return e[CLW-1:0];
    endfunction

    function automatic logic [dosa_pkg::SLOT_OUT_W-1:0] to_out(input logic [SW-1:0] s);
        logic [OXW-1:0] e;
        e = OXW'(s);
        return e[dosa_pkg::SLOT_OUT_W-1:0];
    endfunction

    logic [XW-1:0] ent_x;
    logic          c_ok, s_ok, cl;
    logic [CW-1:0] c_idx;
    logic [VW-1:0] s_idx;

    assign ent_x = XW'(r_ent);
    assign c_ok  = ent_x < XW'(CLIENT_ENTITIES);
    assign s_ok  = ent_x < XW'(SERVER_ENTITIES);
    assign c_idx = CW'(ent_x);
    assign s_idx = VW'(ent_x);
    assign cl    = dosa_pkg::uses_client(r_op);

    // entity range check per operation
    logic bad;
    always_comb begin
        if (r_op == dosa_pkg::OP_CLEAR) begin
            bad = 1'b0;
        end else if (r_op == dosa_pkg::OP_MIRROR) begin
            bad = !c_ok || !s_ok;
        end else if (dosa_pkg::is_client_op(r_op)) begin
            bad = !c_ok;
        end else begin
            bad = !s_ok;
        end
    end

    // next-fit scan: start just after the last allocated slot
    logic [SW:0]     start_full;
    logic [SW-1:0]   start_slot;
    logic [RW-1:0]   next_row;
    logic [RS-1:0]   cand;
    logic [CLW-1:0]  fcol;
    logic            found, scan_end;
    logic [SW-1:0]   found_slot;

    assign start_full = {1'b0, r_last} + (SW+1)'(1);
    assign start_slot = (start_full >= (SW+1)'(POOL_SLOTS)) ? '0 : SW'(start_full);
    assign next_row   = (r_vrow == RW'(ROWS - 1)) ? '0 : r_vrow + RW'(1);
    assign scan_end   = (r_k == KW'(ROWS));

    // free, in-range slots of the row under test
    always_comb begin
        logic [RW+CLW-1:0] sn;
        for (int c = 0; c < RS; c++) begin
            sn = {r_vrow, CLW'(c)};
            cand[c] = (sn != '0) && ((SLX)'(sn) < SLX'(POOL_SLOTS))
                   && ((r_k != '0) || (CLW'(c) >= r_scol))
                   && (!scan_end || (CLW'(c) < r_scol))
                   && !r_own_rd[c] && !r_own_rd[RS+c];
        end
    end

    // lowest free column
    always_comb begin
        fcol = '0;
        for (int c = RS - 1; c >= 0; c--) begin
            if (cand[c]) begin
                fcol = CLW'(c);
            end
        end
    end

    assign found      = |cand;
    assign found_slot = SW'({r_vrow, fcol});

    // ownership bit masks
    logic [2*RS-1:0] set_mask, clr_mask, mset_mask;
    logic [CLW:0]    set_pos, clr_pos, mset_pos;
    logic            other_bit;

    assign set_pos   = {!cl, fcol};
    assign clr_pos   = {!cl, col_of(r_slot)};
    assign mset_pos  = {1'b0, col_of(r_sval)};
    assign set_mask  = (2*RS)'(1) << set_pos;
    assign clr_mask  = (2*RS)'(1) << clr_pos;
    assign mset_mask = (2*RS)'(1) << mset_pos;
    assign other_bit = r_own_rd[{cl, col_of(r_slot)}];

    // memory port control
    logic            own_we, own_re, ct_we, st_we;
    logic [RW-1:0]   own_wa, own_ra;
    logic [2*RS-1:0] own_wd;
    logic [CW-1:0]   ct_wa;
    logic [VW-1:0]   st_wa;
    logic [SW-1:0]   ct_wd, st_wd;

    always_comb begin
        own_we = 1'b0;
        own_re = 1'b0;
        own_wa = row_of(r_slot);
        own_ra = row_of(r_slot);
        own_wd = r_own_rd;
        ct_we  = 1'b0;
        ct_wa  = c_idx;
        ct_wd  = '0;
        st_we  = 1'b0;
        st_wa  = s_idx;
        st_wd  = '0;
        unique case (i_cmd.act)
            dosa_pkg::A_CLR: begin
                own_we = (r_ccnt < DW'(ROWS)) || (ROWS > (1 << DW) - 1);
                own_wa = RW'(r_ccnt);
                own_wd = '0;
                ct_we  = {1'b0, r_ccnt} < (DW+1)'(CLIENT_ENTITIES);
                ct_wa  = CW'(r_ccnt);
                st_we  = {1'b0, r_ccnt} < (DW+1)'(SERVER_ENTITIES);
                st_wa  = VW'(r_ccnt);
            end
            dosa_pkg::A_SCAN0: begin
                own_re = 1'b1;
                own_ra = row_of(start_slot);
            end
            dosa_pkg::A_SCAN: begin
                own_re = 1'b1;
                own_ra = next_row;
                own_we = found;
                own_wa = r_vrow;
                own_wd = r_own_rd | set_mask;
                ct_we  = found && cl;
                ct_wd  = found_slot;
                st_we  = found && !cl;
                st_wd  = found_slot;
            end
            dosa_pkg::A_FREE_RD: begin
                own_re = 1'b1;
                ct_we  = cl;
                st_we  = !cl;
            end
            dosa_pkg::A_FREE_WR: begin
                own_we = 1'b1;
                own_wd = r_own_rd & ~clr_mask;
            end
            dosa_pkg::A_MSET: begin
                own_re = 1'b1;
                own_ra = row_of(r_sval);
                ct_we  = 1'b1;
                ct_wd  = r_sval;
            end
            dosa_pkg::A_MSET_WR: begin
                own_we = 1'b1;
                own_wa = row_of(r_sval);
                own_wd = r_own_rd | mset_mask;
            end
            default: begin
            end
        endcase
    end

    // memory arrays
    always_ff @(posedge i_clk) begin
        if (own_we) begin
            r_own_mem[own_wa] <= own_wd;
        end
        if (own_re) begin
            r_own_rd <= r_own_mem[own_ra];
        end
        if (ct_we) begin
            r_ctab_mem[ct_wa] <= ct_wd;
        end
        if (st_we) begin
            r_stab_mem[st_wa] <= st_wd;
        end
        if (i_cmd.act == dosa_pkg::A_TRD && c_ok) begin
            r_ctab_rd <= r_ctab_mem[c_idx];
        end
        if (i_cmd.act == dosa_pkg::A_TRD && s_ok) begin
            r_stab_rd <= r_stab_mem[s_idx];
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.act)
            dosa_pkg::A_LOAD: begin
                r_op  <= i_op;
                r_ent <= i_entity;
                r_rt  <= i_release_tree;
                r_rel <= '0;
            end
            dosa_pkg::A_TCAP: begin
                r_slot <= cl ? r_ctab_rd : r_stab_rd;
                r_sval <= r_stab_rd;
            end
            dosa_pkg::A_FREE_WR: begin
                r_rel <= other_bit ? '0 : r_slot;
            end
            dosa_pkg::A_SCAN0: begin
                r_vrow <= row_of(start_slot);
                r_scol <= col_of(start_slot);
                r_k    <= '0;
            end
            dosa_pkg::A_SCAN: begin
                r_vrow <= next_row;
                r_k    <= r_k + KW'(1);
                if (found) begin
                    r_slot <= found_slot;
                end
            end
            default: begin
            end
        endcase
    end

    // control state: clear counter and next-fit pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= '0;
            r_last <= SW'(1);
        end else if (i_cmd.act == dosa_pkg::A_CLR) begin
            r_ccnt <= (r_ccnt == DW'(DEPTH - 1)) ? '0 : r_ccnt + DW'(1);
            r_last <= SW'(1);
        end else if (i_cmd.act == dosa_pkg::A_SCAN && found) begin
            r_last <= found_slot;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= (i_cmd.act == dosa_pkg::A_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act == dosa_pkg::A_EMIT) begin
            r_ostat <= i_cmd.st;
            r_oslot <= '0;
            r_orel  <= '0;
            r_orto  <= 1'b0;
            if (i_cmd.st == dosa_pkg::ST_OK) begin
                r_orel <= to_out(r_rel);
                if (r_op == dosa_pkg::OP_MIRROR) begin
                    r_oslot <= to_out(r_sval);
                end else if (r_op == dosa_pkg::OP_CCREATE || r_op == dosa_pkg::OP_SCREATE ||
                             r_op == dosa_pkg::OP_CGET || r_op == dosa_pkg::OP_SGET) begin
                    r_oslot <= to_out(r_slot);
                end
                if ((r_op == dosa_pkg::OP_CFREE || r_op == dosa_pkg::OP_SFREE)
                    && r_rel != '0) begin
                    r_orto <= r_rt;
                end
            end
        end
    end

    assign o_valid            = r_ovalid;
    assign o_status           = r_ostat;
    assign o_slot             = r_oslot;
    assign o_released_slot    = r_orel;
    assign o_release_tree_out = r_orto;

    assign o_dstat.op        = r_op;
    assign o_dstat.bad       = bad;
    assign o_dstat.slot_zero = (r_slot == '0);
    assign o_dstat.sval_zero = (r_sval == '0);
    assign o_dstat.found     = found;
    assign o_dstat.scan_end  = scan_end;
    assign o_dstat.clr_end   = (r_ccnt == DW'(DEPTH - 1));

endmodule

[src/dual_owner_slot_allocator.sv]
// ----------------------------------------------------------------------------
// dual_owner_slot_allocator
// Next-fit pool slot allocator shared by a client and a server owner.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         i_op, i_entity, i_release_tree
//  result    o_valid (1 cycle)    o_status, o_slot, o_released_slot,
//                                 o_release_tree_out
//
//  Create scans one ownership row of 32 slots per cycle through the ownership
//  memory's single read port. Clear all and reset: a clearing sweep of the
//  ownership rows and both entity tables, busy held high.
//  The receiver cannot stall; each result shows for one cycle only.
// ----------------------------------------------------------------------------
module dual_owner_slot_allocator #(
    parameter int POOL_SLOTS      = dosa_pkg::POOL_SLOTS_DEF,
    parameter int CLIENT_ENTITIES = dosa_pkg::CLIENT_ENTITIES_DEF,
    parameter int SERVER_ENTITIES = dosa_pkg::SERVER_ENTITIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dosa_pkg::OP_W-1:0]       i_op,
    input  logic [dosa_pkg::ENT_W-1:0]      i_entity,
    input  logic                            i_release_tree,
    output logic                            o_valid,
    output logic [dosa_pkg::STAT_W-1:0]     o_status,
    output logic [dosa_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic [dosa_pkg::SLOT_OUT_W-1:0] o_released_slot,
    output logic                            o_release_tree_out
);

    dosa_pkg::t_cmd   cmd;
    dosa_pkg::t_dstat dstat;

    // sequencer
    dosa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_dstat (dstat),
        .o_cmd   (cmd)
    );

    // stores, scan and result registers
    dosa_dp #(
        .POOL_SLOTS      (POOL_SLOTS),
        .CLIENT_ENTITIES (CLIENT_ENTITIES),
        .SERVER_ENTITIES (SERVER_ENTITIES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_dstat            (dstat),
        .i_op               (i_op),
        .i_entity           (i_entity),
        .i_release_tree     (i_release_tree),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_slot             (o_slot),
        .o_released_slot    (o_released_slot),
        .o_release_tree_out (o_release_tree_out)
    );

endmodule
